// ----- hdl/itp_pkg.sv -----
// Shared types and constants for the text-to-integer parser.
package itp_pkg;

	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_W     = 32;
	localparam int unsigned RES_W     = 32;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_DIGITS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEX_MODE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT    = 2'd2;

	localparam logic [4:0] MAX_DIGITS_RST = 5'd10;

	// characters of interest
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_LC_A  = 8'h61;
	localparam logic [7:0] CH_LC_F  = 8'h66;
	localparam logic [7:0] CH_UC_A  = 8'h41;
	localparam logic [7:0] CH_UC_F  = 8'h46;
	localparam logic [7:0] CH_LC_X  = 8'h78;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_BLANK,
		PH_SIGNED,
		PH_ZERO,
		PH_DIGITS
	} phase_t;

	// per-character actions decided by the control FSM
	typedef struct packed {
		logic inc_char;   // blank, sign or x of prefix
		logic set_neg;
		logic prefix;     // "0x" seen: restart in hex
		logic take;       // accumulate the decoded digit
		logic emit;
	} act_t;

endpackage

// ----- hdl/integer_text_parser.sv -----
// Streaming ASCII decimal/hex integer parser, one character per transfer.
//
// One character is taken per clock; in_ready is high whenever the result register is empty or
// its contents are taken in the same cycle, so a character stream runs at one transfer per
// cycle. A result is registered at the edge that takes the terminating character (or the last
// digit allowed by max_digits) and is offered on the output channel from the next cycle. The
// whole per-character update (blank/sign/prefix decode, radix multiply-add by shift and add,
// negate and select) sits between the parser state registers and the result register. No
// clearing pass after reset. Configuration is written through cfg_we/cfg_index/cfg_data.
module integer_text_parser #(
	parameter int unsigned VALUE_WIDTH = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// input characters
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [7:0]                     ch,
	input  logic                           start_req,
	// results
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic signed [itp_pkg::RES_W-1:0] value,
	output logic                           valid_res,
	output logic [7:0]                     consumed,
	// configuration
	input  logic                           cfg_we,
	input  logic [itp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [itp_pkg::CFG_W-1:0]      cfg_data
);

	localparam int unsigned EXT_W = (VALUE_WIDTH > itp_pkg::RES_W) ? VALUE_WIDTH : itp_pkg::RES_W;

	// configuration
	logic [4:0]                      max_digits_q;
	logic                            hex_mode_q;
	logic [itp_pkg::RES_W-1:0]       default_q;

	// parser state
	itp_pkg::phase_t                 phase_q, phase_e, phase_d;
	logic                            neg_q, neg_e, neg_d;
	logic                            hex_q, hex_e, hex_d;
	logic [VALUE_WIDTH-1:0]          acc_q, acc_e, acc_d;
	logic [4:0]                      dc_q, dc_e, dc_d;
	logic                            seen_q, seen_e, seen_d;
	logic [7:0]                      cc_q, cc_e, cc_d;

	// result register
	logic                            out_valid_q;
	logic [itp_pkg::RES_W-1:0]       value_q;
	logic                            valid_res_q;
	logic [7:0]                      consumed_q;

	logic                            in_fire;
	itp_pkg::act_t                   act;
	logic [4:0]                      lim;
	logic [4:0]                      dc_take;
	logic [7:0]                      cc_inc;
	logic                            is_blank, is_minus, is_plus, is_zero, is_x;
	logic                            is_dec, is_lc_hex, is_uc_hex, is_digit;
	logic [3:0]                      digit;
	logic [VALUE_WIDTH-1:0]          acc_mul;
	logic [VALUE_WIDTH-1:0]          signed_acc;
	logic [EXT_W-1:0]                acc_ext;
	logic [itp_pkg::RES_W-1:0]       res_value;

	assign in_ready  = !out_valid_q || out_ready;
	assign in_fire   = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign value     = value_q;
	assign valid_res = valid_res_q;
	assign consumed  = consumed_q;

	// start_req restarts the parse before this character is looked at
	always_comb begin
		if (start_req) begin
			phase_e = itp_pkg::PH_BLANK;
			neg_e   = 1'b0;
			hex_e   = hex_mode_q;
			acc_e   = '0;
			dc_e    = '0;
			seen_e  = 1'b0;
			cc_e    = '0;
		end else begin
			phase_e = phase_q;
			neg_e   = neg_q;
			hex_e   = hex_q;
			acc_e   = acc_q;
			dc_e    = dc_q;
			seen_e  = seen_q;
			cc_e    = cc_q;
		end
	end

	// character classes
	assign is_blank  = (ch == itp_pkg::CH_SPACE) || (ch == itp_pkg::CH_TAB);
	assign is_minus  = (ch == itp_pkg::CH_MINUS);
	assign is_plus   = (ch == itp_pkg::CH_PLUS);
	assign is_zero   = (ch == itp_pkg::CH_ZERO);
	assign is_x      = (ch == itp_pkg::CH_LC_X);
	assign is_dec    = (ch >= itp_pkg::CH_ZERO) && (ch <= itp_pkg::CH_NINE);
	assign is_lc_hex = hex_e && (ch >= itp_pkg::CH_LC_A) && (ch <= itp_pkg::CH_LC_F);
	assign is_uc_hex = hex_e && (ch >= itp_pkg::CH_UC_A) && (ch <= itp_pkg::CH_UC_F);
	assign is_digit  = is_dec || is_lc_hex || is_uc_hex;

	always_comb begin
		if (is_lc_hex) begin
			digit = 4'(ch - itp_pkg::CH_LC_A + 8'd10);
		end else if (is_uc_hex) begin
			digit = 4'(ch - itp_pkg::CH_UC_A + 8'd10);
		end else begin
			digit = 4'(ch - itp_pkg::CH_ZERO);
		end
	end

	assign lim     = (max_digits_q == 5'd0) ? 5'd1 : max_digits_q;
	assign dc_take = (dc_e == 5'd31) ? dc_e : dc_e + 5'd1;
	assign cc_inc  = (cc_e == 8'd255) ? cc_e : cc_e + 8'd1;

	// actions for this character
	always_comb begin
		logic digit_path;
		digit_path = 1'b0;
		act        = '0;
		unique case (phase_e)
			itp_pkg::PH_IDLE: begin
			end
			itp_pkg::PH_BLANK: begin
				if (is_blank) begin
					act.inc_char = 1'b1;
				end else if (is_minus) begin
					act.inc_char = 1'b1;
					act.set_neg  = 1'b1;
				end else if (is_plus) begin
					act.inc_char = 1'b1;
				end else if (is_zero) begin
					act.take = 1'b1;
				end else begin
					digit_path = 1'b1;
				end
			end
			itp_pkg::PH_SIGNED: begin
				if (is_zero) begin
					act.take = 1'b1;
				end else begin
					digit_path = 1'b1;
				end
			end
			itp_pkg::PH_ZERO: begin
				if (is_x) begin
					act.inc_char = 1'b1;
					act.prefix   = 1'b1;
				end else if (dc_e >= lim) begin
					act.emit = 1'b1;
				end else begin
					digit_path = 1'b1;
				end
			end
			itp_pkg::PH_DIGITS: begin
				digit_path = 1'b1;
			end
			default: begin
			end
		endcase
		if (digit_path) begin
			if (is_digit) begin
				act.take = 1'b1;
				if (dc_take >= lim) begin
					act.emit = 1'b1;
				end
			end else begin
				act.emit = 1'b1;
			end
		end
	end

	// next phase
	always_comb begin
		phase_d = phase_e;
		unique case (phase_e)
			itp_pkg::PH_IDLE: begin
			end
			itp_pkg::PH_BLANK: begin
				if (is_minus || is_plus) begin
					phase_d = itp_pkg::PH_SIGNED;
				end else if (is_zero) begin
					phase_d = itp_pkg::PH_ZERO;
				end else if (!is_blank) begin
					phase_d = itp_pkg::PH_DIGITS;
				end
			end
			itp_pkg::PH_SIGNED: begin
				if (is_zero) begin
					phase_d = itp_pkg::PH_ZERO;
				end else begin
					phase_d = itp_pkg::PH_DIGITS;
				end
			end
			itp_pkg::PH_ZERO: begin
				phase_d = itp_pkg::PH_DIGITS;
			end
			itp_pkg::PH_DIGITS: begin
			end
			default: begin
			end
		endcase
		if (act.emit) begin
			phase_d = itp_pkg::PH_IDLE;
		end
	end

	// radix multiply by shift and add
	assign acc_mul = hex_e ? (acc_e << 4) : ((acc_e << 3) + (acc_e << 1));

	// datapath updates and result value
	always_comb begin
		neg_d  = neg_e || act.set_neg;
		hex_d  = hex_e || act.prefix;
		acc_d  = acc_e;
		dc_d   = dc_e;
		seen_d = seen_e;
		cc_d   = cc_e;
		if (act.prefix) begin
			acc_d  = '0;
			dc_d   = '0;
			seen_d = 1'b0;
		end
		if (act.take) begin
			acc_d  = acc_mul + VALUE_WIDTH'(digit);
			dc_d   = dc_take;
			seen_d = 1'b1;
		end
		if (act.inc_char || act.take) begin
			cc_d = cc_inc;
		end
		signed_acc = neg_d ? (VALUE_WIDTH'(0) - acc_d) : acc_d;
		acc_ext    = EXT_W'($signed(signed_acc));
		res_value  = seen_d ? acc_ext[itp_pkg::RES_W-1:0] : default_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_digits_q <= itp_pkg::MAX_DIGITS_RST;
			hex_mode_q   <= 1'b0;
			default_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				itp_pkg::CFG_MAX_DIGITS: max_digits_q <= cfg_data[4:0];
				itp_pkg::CFG_HEX_MODE:   hex_mode_q   <= cfg_data[0];
				itp_pkg::CFG_DEFAULT:    default_q    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= itp_pkg::PH_IDLE;
			neg_q   <= 1'b0;
			hex_q   <= 1'b0;
			acc_q   <= '0;
			dc_q    <= '0;
			seen_q  <= 1'b0;
			cc_q    <= '0;
		end else if (in_fire) begin
			phase_q <= phase_d;
			neg_q   <= neg_d;
			hex_q   <= hex_d;
			acc_q   <= acc_d;
			dc_q    <= dc_d;
			seen_q  <= seen_d;
			cc_q    <= cc_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire && act.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && act.emit) begin
			value_q     <= res_value;
			valid_res_q <= seen_d;
			consumed_q  <= cc_d;
		end
	end

	// an emitted result always returns the parser to idle
	a_emit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && act.emit |=> phase_q == itp_pkg::PH_IDLE)
		else $error("parser not idle after result");

	// characters outside a number leave the parser idle
	a_idle_holds: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && !start_req && phase_q == itp_pkg::PH_IDLE |=> phase_q == itp_pkg::PH_IDLE)
		else $error("parser left idle without start");

	// digit count is zero until a digit is taken
	a_no_digit_count: assert property (@(posedge clk) disable iff (!arst_n)
		!seen_q |-> dc_q == 5'd0)
		else $error("digit count without digits");

	// every digit is also a consumed character
	a_char_ge_digit: assert property (@(posedge clk) disable iff (!arst_n)
		cc_q >= 8'(dc_q))
		else $error("char count below digit count");

	// a result is never dropped by a new one
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |-> !in_fire)
		else $error("input taken while result stalled");

endmodule
